// ----- rtl/core/lagged_additive_random_generator_top_defines.svh -----
// assertion helpers shared by the rtl files
`ifndef LAGGED_ADDITIVE_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define LAGGED_ADDITIVE_RANDOM_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define LAGR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LAGR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lagr_pkg.sv -----
`timescale 1ns / 1ps
package lagr_pkg;

   localparam int WORD_W      = 32;
   localparam int RING_LEN    = 17;
   localparam int RING_LAG    = 5;
   localparam int RING_ADDR_W = 5;
   localparam int MOD_STEPS   = 32;
   localparam int MOD_CNT_W   = 5;
   localparam int MAX_DICE    = 255;

   localparam logic [WORD_W-1:0] SUM_INIT        = 32'd728056387;
   localparam logic [WORD_W-1:0] SCALE_RANGE_MAX = 32'h0001_0000;

   localparam logic [2:0] OP_DRAW   = 3'd0;
   localparam logic [2:0] OP_SDRAW  = 3'd1;
   localparam logic [2:0] OP_DICE   = 3'd2;
   localparam logic [2:0] OP_RESEED = 3'd3;
   localparam logic [2:0] OP_INIT   = 3'd4;

   localparam logic [WORD_W-1:0] DEFAULT_RING [RING_LEN] = '{
      32'd1571187604, 32'd2130556662, 32'd2075648113, 32'd1384553414,
      32'd3758113950, 32'd2350400989, 32'd3768155391, 32'd1438658665,
      32'd3424562190, 32'd788898928,  32'd107012447,  32'd2497767687,
      32'd617416951,  32'd3139554167, 32'd2837196932, 32'd224669655,
      32'd4159075602
   };

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

endpackage

// ----- rtl/core/lagr_ram.sv -----
`timescale 1ns / 1ps
module lagr_ram #(
   parameter int WIDTH = lagr_pkg::WORD_W,
   parameter int DEPTH = lagr_pkg::RING_LEN
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- rtl/core/lagr_mod.sv -----
`timescale 1ns / 1ps
`include "lagged_additive_random_generator_top_defines.svh"
module lagr_mod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             dividend,
   input  logic [31:0]             divisor,
   output lagr_pkg::mod_status_type status,
   output logic [31:0]             remainder
);
   import lagr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    dvd_ff, dvd_in;
   logic [WORD_W-1:0]    div_ff, div_in;
   logic [WORD_W:0]      shifted;
   logic [WORD_W:0]      diff;

   // one restoring step per cycle
   assign shifted = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      if (busy_ff) begin
         rem_in = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   `LAGR_ASSERT_IMP(a_mod_start_idle, clock, reset, start, !busy_ff, "mod started while busy")
   `LAGR_ASSERT_NXT(a_mod_done_pulse, clock, reset, done_ff, !done_ff, "mod done held")
   `LAGR_ASSERT_IMP(a_mod_busy_done, clock, reset, busy_ff, !done_ff, "mod busy and done")

endmodule

// ----- rtl/core/lagged_additive_random_generator_top.sv -----
// additive lagged fibonacci generator (lags 17 and 5) with a running 32-bit sum.
// one request item gives one response item. the block takes one item at a time:
// req_stall stays high from acceptance until the result is loaded into the
// response register, which then holds it while the next item is accepted.
// every draw reads two ring words from a 17-entry ram (registered read), so a
// raw draw goes through a read step and then an add step; a reseed discards
// 1 to 32 draws. every draw other than a reseed then passes a reduce step:
// range 0 passes the raw sum, ranges up to 0x10000 use a 16 by 17 multiply in
// that step, and larger ranges go through the remainder unit at one bit per
// cycle. a dice roll repeats the read, add, reduce and sum steps once per die,
// stopping early if the total saturates. reset and the default-init op restore
// the default ring at once through per-entry valid bits, with no clearing pass.
`timescale 1ns / 1ps
`include "lagged_additive_random_generator_top_defines.svh"
module lagged_additive_random_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_range_limit,
   input  logic [31:0] req_seed_value,
   input  logic [7:0]  req_dice_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value
);
   import lagr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ADD,
      ST_REDUCE,
      ST_MODW,
      ST_POST,
      ST_OUT
   } state_type;

   // sequencer and architectural state
   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [WORD_W-1:0]     range_ff, range_in;    // range used for reduction
   logic [WORD_W-1:0]     offset_ff, offset_in;  // subtracted by signed draw
   logic [7:0]            count_ff, count_in;    // dice left
   logic [5:0]            draws_ff, draws_in;    // reseed draws left
   logic [WORD_W-1:0]     acc_ff, acc_in;        // dice running total
   logic [WORD_W-1:0]     raw_ff, raw_in;
   logic [WORD_W-1:0]     red_ff, red_in;
   logic [WORD_W-1:0]     res_ff, res_in;
   logic [RING_ADDR_W-1:0] pos_ff, pos_in;
   logic [WORD_W-1:0]     sum_ff, sum_in;
   logic [RING_LEN-1:0]   valid_ff, valid_in;    // ring word written since default load
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_value_ff, rsp_value_in;

   // ring access
   logic [RING_ADDR_W-1:0] p_eff;
   logic [RING_ADDR_W-1:0] q_raw;
   logic [RING_ADDR_W-1:0] q_eff;
   logic [WORD_W-1:0]      ram_rd_a;
   logic [WORD_W-1:0]      ram_rd_b;
   logic [WORD_W-1:0]      word_a;
   logic [WORD_W-1:0]      word_b;
   logic [WORD_W-1:0]      ring_sum;
   logic [WORD_W-1:0]      next_sum;
   logic                   ram_we;

   // reduction and dice
   logic [32:0]            scale_prod;
   logic [WORD_W:0]        dice_sum;
   logic [7:0]             count_clamp;

   lagr_pkg::mod_status_type mod_sts;
   logic                     mod_start;
   logic [WORD_W-1:0]        mod_rem;

   // a position past the ring end is treated as 0
   assign p_eff = (pos_ff > RING_ADDR_W'(RING_LEN - 1)) ? '0 : pos_ff;
   assign q_raw = p_eff + RING_ADDR_W'(RING_LAG);
   assign q_eff = (q_raw >= RING_ADDR_W'(RING_LEN)) ? q_raw - RING_ADDR_W'(RING_LEN) : q_raw;

   // words never written since the last default load read as the default table
   assign word_a   = valid_ff[p_eff] ? ram_rd_a : DEFAULT_RING[p_eff];
   assign word_b   = valid_ff[q_eff] ? ram_rd_b : DEFAULT_RING[q_eff];
   assign ring_sum = word_a + word_b;
   assign next_sum = sum_ff + ring_sum;
   assign ram_we   = (state_ff == ST_ADD);

   // small ranges: low half of the draw scaled by the range
   assign scale_prod = {17'b0, raw_ff[15:0]} * {16'b0, range_ff[16:0]};

   assign dice_sum = {1'b0, red_ff} + {1'b0, acc_ff};

   assign count_clamp = ({24'b0, req_dice_count} > 32'(MAX_DICE)) ?
                        8'(MAX_DICE) : req_dice_count;

   lagr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_LEN)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (p_eff),
      .wr_data   (ring_sum),
      .rd_addr_a (p_eff),
      .rd_addr_b (q_eff),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   lagr_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (raw_ff),
      .divisor   (range_ff),
      .status    (mod_sts),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      range_in     = range_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      draws_in     = draws_ff;
      acc_in       = acc_ff;
      raw_in       = raw_ff;
      red_in       = red_ff;
      res_in       = res_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      mod_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               range_in  = req_range_limit;
               offset_in = '0;
               unique case (req_op)
                  OP_DRAW: begin
                     state_in = ST_READ;
                  end
                  OP_SDRAW: begin
                     range_in  = {req_range_limit[WORD_W-2:0], 1'b0};
                     offset_in = req_range_limit;
                     state_in  = ST_READ;
                  end
                  OP_DICE: begin
                     count_in = count_clamp;
                     acc_in   = {24'b0, count_clamp};
                     if ((count_clamp == '0) || (req_range_limit == '0)) begin
                        res_in   = '0;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  OP_RESEED: begin
                     valid_in = '0;
                     sum_in   = '0 - req_seed_value;
                     pos_in   = {1'b0, req_seed_value[3:0]};
                     draws_in = {1'b0, req_seed_value[12:8]} + 6'd1;
                     state_in = ST_READ;
                  end
                  OP_INIT: begin
                     valid_in = '0;
                     sum_in   = SUM_INIT;
                     pos_in   = '0;
                     res_in   = '0;
                     state_in = ST_OUT;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         // ram read in flight
         ST_READ: begin
            state_in = ST_ADD;
         end
         // lagged add, write back, step the position
         ST_ADD: begin
            valid_in[p_eff] = 1'b1;
            sum_in          = next_sum;
            raw_in          = next_sum;
            pos_in          = (p_eff == '0) ? RING_ADDR_W'(RING_LEN - 1) : p_eff - 1'b1;
            if (op_ff == OP_RESEED) begin
               draws_in = draws_ff - 1'b1;
               if (draws_ff == 6'd1) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (range_ff == '0) begin
               red_in   = raw_ff;
               state_in = ST_POST;
            end else if (range_ff > SCALE_RANGE_MAX) begin
               mod_start = 1'b1;
               state_in  = ST_MODW;
            end else begin
               red_in   = {15'b0, scale_prod[32:16]};
               state_in = ST_POST;
            end
         end
         ST_MODW: begin
            if (mod_sts.done) begin
               red_in   = mod_rem;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (op_ff == OP_DICE) begin
               if (dice_sum[WORD_W]) begin
                  // saturate and skip the remaining dice
                  res_in   = '1;
                  state_in = ST_OUT;
               end else begin
                  acc_in   = dice_sum[WORD_W-1:0];
                  count_in = count_ff - 1'b1;
                  if (count_ff == 8'd1) begin
                     res_in   = dice_sum[WORD_W-1:0];
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end else begin
               res_in   = red_ff - offset_ff;
               state_in = ST_OUT;
            end
         end
         // wait for the response register to free up
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= SUM_INIT;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
      end
      op_ff        <= op_in;
      range_ff     <= range_in;
      offset_ff    <= offset_in;
      count_ff     <= count_in;
      draws_ff     <= draws_in;
      acc_ff       <= acc_in;
      raw_ff       <= raw_in;
      red_ff       <= red_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   `LAGR_ASSERT_IMP(a_pos_range, clock, reset, 1'b1,
      pos_ff <= RING_ADDR_W'(RING_LEN - 1), "ring position out of range")
   `LAGR_ASSERT_NXT(a_pos_step, clock, reset, state_ff == ST_ADD,
      pos_ff == (($past(p_eff) == '0) ? RING_ADDR_W'(RING_LEN - 1) : $past(p_eff) - 1'b1),
      "ring position did not step down")
   `LAGR_ASSERT_IMP(a_mod_wait, clock, reset, state_ff == ST_MODW,
      mod_sts.busy || mod_sts.done, "waiting on idle remainder unit")
   `LAGR_ASSERT_IMP(a_dice_left, clock, reset, (state_ff == ST_POST) && (op_ff == OP_DICE),
      count_ff != '0, "dice roll with no dice left")

endmodule
